[design/mwjd_pkg.sv]
package mwjd_pkg;

  localparam int NUM_WORKERS  = 3;
  localparam int QUEUE_DEPTH  = 5;
  localparam int ID_BITS      = 16;
  localparam int DUR_BITS     = 8;
  localparam int CNT_BITS     = 16;
  localparam int TICK_BITS    = 32;
  localparam int OP_BITS      = 2;
  localparam int OUTCOME_BITS = 2;
  localparam int WIDX_BITS    = 2;
  localparam int MASK_BITS    = 3;
  localparam int QFIELD_BITS  = 3;

  localparam int QLEN_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam int POP_BITS  = $clog2(NUM_WORKERS + 1);
  localparam int HIDX_BITS = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int CMP_BITS  = QLEN_BITS + POP_BITS;

  localparam int S_DATA_BITS = 24;
  localparam int M_DATA_BITS = 88;

  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

  typedef enum logic [OP_BITS-1:0] {
    OP_ARRIVE = 2'd0,
    OP_TICK   = 2'd1,
    OP_CLOSE  = 2'd2,
    OP_IDLE   = 2'd3
  } op_t;

  typedef enum logic [OUTCOME_BITS-1:0] {
    OUT_STARTED = 2'd0,
    OUT_QUEUED  = 2'd1,
    OUT_DROPPED = 2'd2,
    OUT_NONE    = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [ID_BITS-1:0]  job;
    logic [DUR_BITS-1:0] dur;
  } slot_t;

  typedef struct packed {
    logic arrive;
    logic tick;
    logic close;
  } cmd_t;

  // handed from one worker to the next: arrival already taken, heads popped so far
  typedef struct packed {
    logic                placed;
    logic [POP_BITS-1:0] pops;
  } chain_t;

  function automatic logic [CNT_BITS-1:0] sat_add(input logic [CNT_BITS-1:0] a,
                                                  input logic [CNT_BITS-1:0] b);
    logic [CNT_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CNT_BITS] ? CNT_MAX : sum[CNT_BITS-1:0];
  endfunction

endpackage

[design/mwjd_worker.sv]
module mwjd_worker (
  input  logic                                clk,
  input  logic                                rst,
  input  mwjd_pkg::cmd_t                      cmd,
  input  mwjd_pkg::slot_t                     arr,
  input  mwjd_pkg::slot_t                     head [mwjd_pkg::NUM_WORKERS],
  input  logic [mwjd_pkg::QLEN_BITS-1:0]      qlen,
  input  mwjd_pkg::chain_t                    chain_in,
  output mwjd_pkg::chain_t                    chain_out,
  output logic                                busy,
  output logic                                started,
  output logic                                done
);
  import mwjd_pkg::*;

  logic [DUR_BITS-1:0] remaining;
  logic [ID_BITS-1:0]  job;
  logic                last_tick;
  logic                take_head;
  slot_t               head_sel;

  assign last_tick = (remaining == DUR_BITS'(1));
  assign started   = cmd.arrive && !busy && !chain_in.placed;
  assign done      = cmd.tick && busy && last_tick;
  assign take_head = cmd.tick && (!busy || last_tick)
                     && (CMP_BITS'(chain_in.pops) < CMP_BITS'(qlen));
  assign head_sel  = head[chain_in.pops[HIDX_BITS-1:0]];

  assign chain_out.placed = chain_in.placed || (cmd.arrive && !busy);
  assign chain_out.pops   = chain_in.pops + POP_BITS'(take_head);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      remaining <= '0;
    end else if (cmd.close) begin
      busy      <= 1'b0;
      remaining <= '0;
    end else if (started) begin
      busy      <= 1'b1;
      remaining <= arr.dur;
    end else if (take_head) begin
      busy      <= 1'b1;
      remaining <= head_sel.dur;
    end else if (cmd.tick && busy) begin
      remaining <= remaining - DUR_BITS'(1);
      if (last_tick) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (started) begin
      job <= arr.job;
    end else if (take_head) begin
      job <= head_sel.job;
    end
  end

endmodule

[design/mwjd_slot.sv]
module mwjd_slot (
  input  logic                           clk,
  input  logic                           load_arr,
  input  mwjd_pkg::slot_t                arr,
  input  logic [mwjd_pkg::POP_BITS-1:0]  pops,
  input  mwjd_pkg::slot_t                win [mwjd_pkg::NUM_WORKERS],
  output mwjd_pkg::slot_t                q
);
  import mwjd_pkg::*;

  logic [POP_BITS-1:0] sel;

  // shift in the entry that sits pops places further back
  assign sel = pops - POP_BITS'(1);

  always_ff @(posedge clk) begin
    if (load_arr) begin
      q <= arr;
    end else if (pops != '0) begin
      q <= win[sel[HIDX_BITS-1:0]];
    end
  end

endmodule

[design/multi_worker_job_dispatcher.sv]
// Job dispatcher with a row of worker timers and a compacting wait queue.
// Input channel s_*: one item per event. s_tuser carries the op (arrival,
// tick, close, idle); s_tdata carries job_id and duration for arrivals.
// Output channel m_*: one result per accepted item. m_tuser carries the
// outcome; m_tdata carries worker index, busy mask, queue length, the
// served, dropped and cancelled counters and the tick count.
// The result is registered and valid in the cycle after the item is accepted.
// Throughput: one item per cycle while results are taken; each event settles
// in a single pass along the worker chain and one shift of the slot chain.
// Reset clears all workers, empties the queue and zeroes every counter;
// m_tvalid is low after reset.
// When the receiver stalls, the result holds on m_* and s_tready stays low
// until it is taken; s_tready rises again in the cycle the result leaves.
// Counters saturate at their maximum; the tick count wraps.
module multi_worker_job_dispatcher (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [mwjd_pkg::S_DATA_BITS-1:0]     s_tdata,  // job_id, duration
  input  logic [mwjd_pkg::OP_BITS-1:0]         s_tuser,  // op
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // worker_index, busy_mask, queue_length, served_count, dropped_count,
  // cancelled_count, elapsed_ticks
  output logic [mwjd_pkg::M_DATA_BITS-1:0]     m_tdata,
  output logic [mwjd_pkg::OUTCOME_BITS-1:0]    m_tuser   // outcome
);
  import mwjd_pkg::*;

  logic                    accept;
  op_t                     op;
  cmd_t                    cmd;
  slot_t                   arr;
  logic [DUR_BITS-1:0]     dur_in;

  chain_t                  chain [NUM_WORKERS+1];
  logic [NUM_WORKERS-1:0]  busy;
  logic [NUM_WORKERS-1:0]  started;
  logic [NUM_WORKERS-1:0]  done;
  slot_t                   head [NUM_WORKERS];

  slot_t                   slot_q [QUEUE_DEPTH];
  slot_t                   win [QUEUE_DEPTH][NUM_WORKERS];

  logic [QLEN_BITS-1:0]    qlen;
  logic [QLEN_BITS-1:0]    qlen_next;
  logic                    queue_full;
  logic                    to_queue;
  logic                    to_drop;

  logic [CNT_BITS-1:0]     served;
  logic [CNT_BITS-1:0]     dropped;
  logic [CNT_BITS-1:0]     cancelled;
  logic [TICK_BITS-1:0]    ticks;
  logic [POP_BITS-1:0]     n_done;
  logic [POP_BITS-1:0]     n_busy;

  outcome_t                outcome;
  outcome_t                outcome_next;
  logic [WIDX_BITS-1:0]    widx;
  logic [WIDX_BITS-1:0]    widx_next;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign op       = op_t'(s_tuser);

  assign cmd.arrive = accept && (op == OP_ARRIVE);
  assign cmd.tick   = accept && (op == OP_TICK);
  assign cmd.close  = accept && (op == OP_CLOSE);

  // zero duration runs as one tick
  assign dur_in  = s_tdata[ID_BITS +: DUR_BITS];
  assign arr.job = s_tdata[ID_BITS-1:0];
  assign arr.dur = (dur_in == '0) ? DUR_BITS'(1) : dur_in;

  assign chain[0] = '0;

  for (genvar i = 0; i < NUM_WORKERS; i++) begin : g_head
    if (i < QUEUE_DEPTH) begin : g_slot
      assign head[i] = slot_q[i];
    end else begin : g_none
      assign head[i] = '0;
    end
  end

  for (genvar w = 0; w < NUM_WORKERS; w++) begin : g_worker
    mwjd_worker u_worker (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .arr      (arr),
      .head     (head),
      .qlen     (qlen),
      .chain_in (chain[w]),
      .chain_out(chain[w+1]),
      .busy     (busy[w]),
      .started  (started[w]),
      .done     (done[w])
    );
  end

  assign queue_full = (qlen == QLEN_BITS'(QUEUE_DEPTH));
  assign to_queue   = cmd.arrive && !chain[NUM_WORKERS].placed && !queue_full;
  assign to_drop    = cmd.arrive && !chain[NUM_WORKERS].placed && queue_full;

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_queue
    for (genvar j = 0; j < NUM_WORKERS; j++) begin : g_win
      if (k + 1 + j < QUEUE_DEPTH) begin : g_slot
        assign win[k][j] = slot_q[k+1+j];
      end else begin : g_none
        assign win[k][j] = '0;
      end
    end

    mwjd_slot u_slot (
      .clk     (clk),
      .load_arr(to_queue && (qlen == QLEN_BITS'(k))),
      .arr     (arr),
      .pops    (chain[NUM_WORKERS].pops),
      .win     (win[k]),
      .q       (slot_q[k])
    );
  end

  always_comb begin
    n_done    = '0;
    n_busy    = '0;
    widx_next = '0;
    for (int w = 0; w < NUM_WORKERS; w++) begin
      n_done = n_done + POP_BITS'(done[w]);
      n_busy = n_busy + POP_BITS'(busy[w]);
      if (started[w]) begin
        widx_next = WIDX_BITS'(w);
      end
    end
  end

  always_comb begin
    qlen_next = qlen;
    if (cmd.close) begin
      qlen_next = '0;
    end else if (to_queue) begin
      qlen_next = qlen + QLEN_BITS'(1);
    end else if (cmd.tick) begin
      qlen_next = qlen - QLEN_BITS'(chain[NUM_WORKERS].pops);
    end
  end

  always_comb begin
    outcome_next = OUT_NONE;
    if (cmd.arrive) begin
      if (chain[NUM_WORKERS].placed) begin
        outcome_next = OUT_STARTED;
      end else if (queue_full) begin
        outcome_next = OUT_DROPPED;
      end else begin
        outcome_next = OUT_QUEUED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qlen      <= '0;
      served    <= '0;
      dropped   <= '0;
      cancelled <= '0;
      ticks     <= '0;
      m_tvalid  <= 1'b0;
      outcome   <= OUT_NONE;
      widx      <= '0;
    end else begin
      qlen <= qlen_next;
      if (cmd.tick) begin
        ticks  <= ticks + TICK_BITS'(1);
        served <= sat_add(served, CNT_BITS'(n_done));
      end
      if (to_drop) begin
        dropped <= sat_add(dropped, CNT_BITS'(1));
      end
      if (cmd.close) begin
        cancelled <= sat_add(cancelled, CNT_BITS'(n_busy) + CNT_BITS'(qlen));
      end
      if (accept) begin
        m_tvalid <= 1'b1;
        outcome  <= outcome_next;
        widx     <= widx_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result reads the state left by the item it answers
  assign m_tuser = outcome;
  assign m_tdata = {ticks, cancelled, dropped, served,
                    QFIELD_BITS'(qlen), MASK_BITS'(busy), widx};

endmodule
